FILE: rtl/core/llca_pkg.sv
// Shared types and constants for the least-loaded core allocator.
// Holds request/response payload structs, action and register codes, FSM states.
// No dependencies.
package llca_pkg;

    localparam int LOAD_W   = 20;
    localparam int EFF_W    = LOAD_W + 1;
    localparam int PART_W   = 24;
    localparam int CC_W     = 7;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 6;
    localparam int CADDR_W  = 2;

    // load memory depth and the widths derived from it
    localparam int MAX_CORES = 64;
    localparam int AW        = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int NW_RAW    = $clog2(MAX_CORES + 1);
    localparam int NW        = (NW_RAW > CC_W) ? NW_RAW : CC_W;
    localparam int PW        = NW + CFG_W;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam logic [PART_W-1:0] PART_MAX = '1;

    localparam logic [CC_W-1:0]  CORE_COUNT_RST = 7'd8;
    localparam logic [CFG_W-1:0] PPC_RST        = 16'd1000;
    localparam logic [CFG_W-1:0] RESERVE_RST    = 16'd2;

    // configuration register indexes
    localparam logic [CADDR_W-1:0] REG_CORE_COUNT = 2'd0;
    localparam logic [CADDR_W-1:0] REG_PPC        = 2'd1;
    localparam logic [CADDR_W-1:0] REG_RESERVE    = 2'd2;

    // request action codes
    localparam logic [2:0] ACT_CHOOSE   = 3'd0;
    localparam logic [2:0] ACT_ADD_CORE = 3'd1;
    localparam logic [2:0] ACT_REM_CORE = 3'd2;
    localparam logic [2:0] ACT_ADD_PART = 3'd3;
    localparam logic [2:0] ACT_REM_PART = 3'd4;
    localparam logic [2:0] ACT_QUERY    = 3'd5;

    typedef struct packed {
        logic [2:0]        action;
        logic [CIDX_W-1:0] core_index;
        logic              will_add;
        logic              exempt;
    } req_t;

    typedef struct packed {
        logic [CIDX_W-1:0] chosen_core;
        logic              full_res;
        logic              error;
        logic [PART_W-1:0] partition_total;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_CHOOSE_WR,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/llca_cfg.sv
// Configuration registers, clamped core count and registered capacity product.
// Depends on llca_pkg.
module llca_cfg
    import llca_pkg::*;
(
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [CADDR_W-1:0]                     cfg_addr,
    input  logic [CFG_W-1:0]                       cfg_wdata,
    output logic [NW-1:0]                          cores_used,
    output logic [CFG_W-1:0]                       reserve,
    output logic [PW-1:0]                          cap_prod,
    output logic                                   clr_en,
    output logic [NW-1:0]                          clr_from
);
    logic [CC_W-1:0]  ccount_reg;
    logic [CFG_W-1:0] ppc_reg;
    logic [CFG_W-1:0] reserve_reg;
    logic [PW-1:0]    prod_reg;
    logic [PW-1:0]    prod_next;

    function automatic logic [NW-1:0] clamp_count(input logic [CC_W-1:0] cc);
        logic [NW-1:0] w;
        w = NW'(cc);
        if (w == '0) begin
            return NW'(1);
        end else if (w > NW'(MAX_CORES)) begin
            return NW'(MAX_CORES);
        end
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ccount_reg  <= CORE_COUNT_RST;
            ppc_reg     <= PPC_RST;
            reserve_reg <= RESERVE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CORE_COUNT: ccount_reg  <= cfg_wdata[CC_W-1:0];
                REG_PPC:        ppc_reg     <= cfg_wdata;
                REG_RESERVE:    reserve_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cores_used = clamp_count(ccount_reg);
    assign prod_next  = PW'(cores_used) * PW'(ppc_reg);

    // product is a register behind the config; a query reads it in the cycle after acceptance
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign reserve  = reserve_reg;
    assign cap_prod = prod_reg;
    assign clr_en   = cfg_wr_en && (cfg_addr == REG_CORE_COUNT);
    assign clr_from = clamp_count(cfg_wdata[CC_W-1:0]);

endmodule

FILE: rtl/core/llca_load_mem.sv
// Per-core load memory: one write port, one registered read port, valid bit per entry.
// Entries not valid read as zero. Depends on llca_pkg.
module llca_load_mem
    import llca_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [LOAD_W-1:0] rd_load,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [LOAD_W-1:0] wr_load,
    input  logic              clr_en,
    input  logic [NW-1:0]     clr_from
);
    logic [LOAD_W-1:0]    load_ram [MAX_CORES];
    logic [LOAD_W-1:0]    rdata_reg;
    logic                 rvalid_reg;
    logic [MAX_CORES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            load_ram[wr_addr] <= wr_load;
        end
        if (rd_en) begin
            rdata_reg <= load_ram[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            // dropping cores invalidates their entries at once
            for (int i = 0; i < MAX_CORES; i++) begin
                if (clr_en && (NW'(i) >= clr_from)) begin
                    valid_reg[i] <= 1'b0;
                end
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_load = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: rtl/core/llca_ctrl.sv
// Request sequencer: least-load scan, read-modify-write of core loads, partition count.
// Depends on llca_pkg; drives llca_load_mem ports.
module llca_ctrl
    import llca_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output rsp_t              res,
    input  logic [NW-1:0]     cores_used,
    input  logic [CFG_W-1:0]  reserve,
    input  logic [PW-1:0]     cap_prod,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [LOAD_W-1:0] rd_load,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [LOAD_W-1:0] wr_load
);
    localparam int CMPW   = (PW > PART_W + 1) ? PW : PART_W + 1;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [EFF_W-1:0]  best_eff_reg, best_eff_next;
    logic [LOAD_W-1:0] best_raw_reg, best_raw_next;
    logic [PART_W-1:0] pc_reg, pc_next;
    logic [CIDX_W-1:0] chosen_reg, chosen_next;
    logic              full_reg, full_next;
    logic              err_reg, err_next;

    logic              first_data;
    logic [EFF_W-1:0]  eff_in;
    logic [AW-1:0]     data_idx;
    logic              idx_ok;
    logic [PW-1:0]     cap;
    logic [PART_W:0]   pc_plus;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        best_idx_reg <= best_idx_next;
        best_eff_reg <= best_eff_next;
        best_raw_reg <= best_raw_next;
        chosen_reg   <= chosen_next;
        full_reg     <= full_next;
        err_reg      <= err_next;
    end

    assign idx_ok     = NW'(item_reg.core_index) < cores_used;
    assign cap        = (cap_prod > PW'(reserve)) ? (cap_prod - PW'(reserve)) : '0;
    assign pc_plus    = (PART_W + 1)'(pc_reg) + (PART_W + 1)'(item_reg.will_add);
    // data arriving in the scan belongs to the address issued in the previous cycle
    assign first_data = (cnt_reg == NW'(1));
    assign data_idx   = AW'(cnt_reg - NW'(1));
    assign eff_in     = first_data ? (EFF_W'(rd_load) + EFF_W'(reserve)) : EFF_W'(rd_load);

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        cnt_next      = cnt_reg;
        best_idx_next = best_idx_reg;
        best_eff_next = best_eff_reg;
        best_raw_next = best_raw_reg;
        pc_next       = pc_reg;
        chosen_next   = chosen_reg;
        full_next     = full_reg;
        err_next      = err_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_load       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    item_next  = req;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                chosen_next = '0;
                full_next   = 1'b0;
                err_next    = 1'b0;
                state_next  = ST_DONE;
                unique case (item_reg.action) inside
                    ACT_CHOOSE: begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        cnt_next   = NW'(1);
                        state_next = ST_SCAN;
                    end
                    ACT_ADD_CORE, ACT_REM_CORE: begin
                        if (idx_ok) begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(item_reg.core_index);
                            state_next = ST_MODIFY;
                        end else begin
                            err_next = 1'b1;
                        end
                    end
                    ACT_ADD_PART: begin
                        if (pc_reg != PART_MAX) begin
                            pc_next = pc_reg + PART_W'(1);
                        end
                    end
                    ACT_REM_PART: begin
                        if (pc_reg == '0) begin
                            err_next = 1'b1;
                        end else begin
                            pc_next = pc_reg - PART_W'(1);
                        end
                    end
                    ACT_QUERY: begin
                        full_next = !item_reg.exempt && (CMPW'(pc_plus) > CMPW'(cap));
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                // strict compare keeps the first core of equal load
                if (first_data || (eff_in < best_eff_reg)) begin
                    best_idx_next = data_idx;
                    best_eff_next = eff_in;
                    best_raw_next = rd_load;
                end
                if (cnt_reg < cores_used) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(cnt_reg);
                    cnt_next = cnt_reg + NW'(1);
                end else begin
                    state_next = ST_CHOOSE_WR;
                end
            end
            ST_CHOOSE_WR: begin
                wr_en       = 1'b1;
                wr_addr     = best_idx_reg;
                wr_load     = (best_raw_reg != LOAD_MAX) ? best_raw_reg + LOAD_W'(1)
                                                         : best_raw_reg;
                chosen_next = CIDX_W'(best_idx_reg);
                state_next  = ST_DONE;
            end
            ST_MODIFY: begin
                wr_addr    = AW'(item_reg.core_index);
                state_next = ST_DONE;
                if (item_reg.action == ACT_ADD_CORE) begin
                    wr_en   = 1'b1;
                    wr_load = (rd_load != LOAD_MAX) ? rd_load + LOAD_W'(1) : rd_load;
                end else if (rd_load == '0) begin
                    err_next = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_load = rd_load - LOAD_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.chosen_core     = chosen_reg;
        res.full_res        = full_reg;
        res.error           = err_reg;
        res.partition_total = pc_reg;
    end

endmodule

FILE: rtl/core/least_loaded_core_allocator_top.sv
// Least-loaded core allocator: request/response channels, config port, load memory.
// Depends on llca_pkg, llca_cfg, llca_load_mem, llca_ctrl.
//
// Usage:
//   Requests arrive on s_valid/s_ready with an s_req payload; every request
//   returns exactly one response on m_valid/m_ready with an m_rsp payload.
//   Registers are written through cfg_wr_en/cfg_addr/cfg_wdata while idle;
//   writing the core count drops the load of every core at or above it.
//   One request is in work at a time. A choose request scans the n cores in
//   use one memory read per cycle (n is 8 after reset, up to MAX_CORES), then
//   writes back the chosen core's load. Add/remove on a core takes a
//   read-modify-write (no memory access for a bad index); partition and query
//   requests answer without a memory access. The next request is accepted the
//   cycle after the result moves to the output register; a request overlaps a
//   stalled receiver.
//   Reset (aresetn low, synchronous) clears all core loads through per-entry
//   valid bits at once, zeroes the partition count and restores the register
//   defaults; no clearing pass is needed. If m_ready stays low the response
//   holds and one further request can be finished behind it.
module least_loaded_core_allocator_top
    import llca_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output rsp_t               m_rsp,
    input  logic               cfg_wr_en,
    input  logic [CADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);
    logic [NW-1:0]     cores_used;
    logic [CFG_W-1:0]  reserve;
    logic [PW-1:0]     cap_prod;
    logic              clr_en;
    logic [NW-1:0]     clr_from;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [LOAD_W-1:0] rd_load;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LOAD_W-1:0] wr_load;
    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_rsp_reg, m_rsp_next;

    llca_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cores_used (cores_used),
        .reserve    (reserve),
        .cap_prod   (cap_prod),
        .clr_en     (clr_en),
        .clr_from   (clr_from)
    );

    llca_load_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_load  (rd_load),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_load  (wr_load),
        .clr_en   (clr_en),
        .clr_from (clr_from)
    );

    llca_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req        (s_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cores_used (cores_used),
        .reserve    (reserve),
        .cap_prod   (cap_prod),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_load    (rd_load),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_load    (wr_load)
    );

    // output register decouples the receiver from the sequencer
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_rsp_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

FILE: rtl/core/llca_checker.sv
// Port-level checks for the allocator top, attached by bind.
// Depends on llca_pkg and least_loaded_core_allocator_top.
module llca_checker
    import llca_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid right after reset");

    // one request in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

    // full and error never rise together, and a nonzero chosen core comes with neither flag
    a_rsp_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rsp.full_res && m_rsp.error)
                    && ((m_rsp.chosen_core == '0) || (!m_rsp.full_res && !m_rsp.error)))
        else $error("inconsistent response flags");

endmodule

bind least_loaded_core_allocator_top llca_checker u_llca_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

FILE: sim/tb_least_loaded_core_allocator_top.sv
// Self-checking testbench for least_loaded_core_allocator_top: directed and random requests,
// register changes between phases, a request-level load/partition tracker and a scoreboard.
// Depends on llca_pkg and the allocator RTL.
module tb_least_loaded_core_allocator_top;
    import llca_pkg::*;

    localparam int NUM_CORES      = MAX_CORES;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 110;

    // action codes the block leaves unused
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    class alloc_tracker;
        logic [LOAD_W-1:0] core_load [NUM_CORES];
        logic [PART_W-1:0] part_cnt;
        logic [CC_W-1:0]   ncores;
        logic [CFG_W-1:0]  per_core;
        logic [CFG_W-1:0]  reserve;
        rsp_t              pending_rsp [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       full_seen;
        int unsigned       err_seen;

        function new();
            foreach (core_load[i]) core_load[i] = '0;
            part_cnt   = '0;
            ncores     = CORE_COUNT_RST;
            per_core   = PPC_RST;
            reserve    = RESERVE_RST;
            mismatches = 0;
            checked    = 0;
            full_seen  = 0;
            err_seen   = 0;
        endfunction

        function int unsigned active_cores();
            if (ncores == 0) return 1;
            if (ncores > NUM_CORES) return NUM_CORES;
            return 32'(ncores);
        endfunction

        function longint unsigned capacity();
            longint unsigned total;
            total = longint'(active_cores()) * per_core;
            return (total > reserve) ? total - reserve : 0;
        endfunction

        function int unsigned outstanding();
            return pending_rsp.size();
        endfunction

        function void write_reg(logic [CADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_CORE_COUNT: begin
                    ncores = val[CC_W-1:0];
                    for (int i = active_cores(); i < NUM_CORES; i++) core_load[i] = '0;
                end
                REG_PPC:     per_core = val;
                REG_RESERVE: reserve  = val;
                default: ;
            endcase
        endfunction

        function void note_request(req_t r);
            int unsigned n;
            int unsigned best;
            int unsigned best_eff;
            rsp_t e;
            n = active_cores();
            e = '0;
            case (r.action)
                ACT_CHOOSE: begin
                    // core 0 competes with its reserve added on top
                    best = 0;
                    best_eff = 32'(core_load[0]) + 32'(reserve);
                    for (int i = 1; i < n; i++) begin
                        if (32'(core_load[i]) < best_eff) begin
                            best_eff = 32'(core_load[i]);
                            best = i;
                        end
                    end
                    if (core_load[best] != LOAD_MAX) core_load[best]++;
                    e.chosen_core = CIDX_W'(best);
                end
                ACT_ADD_CORE: begin
                    if (r.core_index >= n) e.error = 1'b1;
                    else if (core_load[r.core_index] != LOAD_MAX) core_load[r.core_index]++;
                end
                ACT_REM_CORE: begin
                    if (r.core_index >= n || core_load[r.core_index] == 0) e.error = 1'b1;
                    else core_load[r.core_index]--;
                end
                ACT_ADD_PART: begin
                    if (part_cnt != PART_MAX) part_cnt++;
                end
                ACT_REM_PART: begin
                    if (part_cnt == 0) e.error = 1'b1;
                    else part_cnt--;
                end
                ACT_QUERY: begin
                    if (!r.exempt && (longint'(part_cnt) + r.will_add) > capacity())
                        e.full_res = 1'b1;
                end
                default: ;
            endcase
            e.partition_total = part_cnt;
            pending_rsp = {pending_rsp, e};
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (pending_rsp.size() == 0) begin
                $error("response with no request waiting: %h", got);
                mismatches++;
                return;
            end
            e = pending_rsp.pop_front();
            checked++;
            if (got.full_res === 1'b1) full_seen++;
            if (got.error === 1'b1) err_seen++;
            if (got.chosen_core !== e.chosen_core) begin
                $error("chosen_core expected %0d got %0d", e.chosen_core, got.chosen_core);
                mismatches++;
            end
            if (got.full_res !== e.full_res) begin
                $error("full_res expected %0d got %0d", e.full_res, got.full_res);
                mismatches++;
            end
            if (got.error !== e.error) begin
                $error("error expected %0d got %0d", e.error, got.error);
                mismatches++;
            end
            if (got.partition_total !== e.partition_total) begin
                $error("partition_total expected %0d got %0d",
                       e.partition_total, got.partition_total);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    req_t               s_req;
    logic               m_valid;
    logic               m_ready;
    rsp_t               m_rsp;
    logic               cfg_wr_en;
    logic [CADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;

    alloc_tracker sb = new();

    bit          src_idle;
    bit          sink_idle;
    bit          hold_off_req;
    int unsigned req_cnt;
    int unsigned cfg_cnt;
    int unsigned idle_cycles;

    always #5 aclk = ~aclk;

    least_loaded_core_allocator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_response(m_rsp);
    end

    // watchdog: cycles with no transfer on any port
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // response side: random stall bursts and one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle && $urandom_range(0, 99) < 15) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic req_t mk_req(logic [2:0] act, int unsigned idx, bit wa, bit ex);
        req_t r;
        r.action     = act;
        r.core_index = CIDX_W'(idx);
        r.will_add   = wa;
        r.exempt     = ex;
        return r;
    endfunction

    function automatic req_t random_req(int unsigned n);
        req_t        r;
        int unsigned v;
        v = $urandom_range(0, 99);
        if (v < 25)      r.action = ACT_CHOOSE;
        else if (v < 40) r.action = ACT_ADD_CORE;
        else if (v < 55) r.action = ACT_REM_CORE;
        else if (v < 70) r.action = ACT_ADD_PART;
        else if (v < 80) r.action = ACT_REM_PART;
        else if (v < 95) r.action = ACT_QUERY;
        else             r.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        // mostly cores in use, sometimes any index
        if ($urandom_range(0, 9) < 7) r.core_index = CIDX_W'($urandom_range(0, n - 1));
        else                          r.core_index = CIDX_W'($urandom_range(0, 63));
        r.will_add = 1'($urandom_range(0, 1));
        r.exempt   = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic send_item(input req_t r);
        if (src_idle && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        req_cnt++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cfg_cnt++;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] ppc,
                            input logic [CFG_W-1:0] rsv);
        settle();
        write_reg(REG_CORE_COUNT, cc);
        write_reg(REG_PPC, ppc);
        write_reg(REG_RESERVE, rsv);
    endtask

    task automatic random_regs();
        logic [CFG_W-1:0] cc;
        logic [CFG_W-1:0] ppc;
        logic [CFG_W-1:0] rsv;
        case ($urandom_range(0, 9))
            0:       cc = '0;
            1:       cc = CFG_W'(1);
            2:       cc = CFG_W'(NUM_CORES);
            3:       cc = CFG_W'(127);
            4:       cc = CFG_W'($urandom_range(NUM_CORES + 1, 127));
            5:       cc = CFG_W'($urandom_range(33, NUM_CORES - 1));
            default: cc = CFG_W'($urandom_range(2, 12));
        endcase
        // bits above the core count field are don't-care
        cc[CFG_W-1:CC_W] = (CFG_W - CC_W)'($urandom);
        case ($urandom_range(0, 5))
            0:       ppc = '0;
            1:       ppc = 16'hFFFF;
            2:       ppc = CFG_W'($urandom);
            default: ppc = CFG_W'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       rsv = '0;
            1:       rsv = 16'hFFFF;
            2:       rsv = CFG_W'($urandom);
            default: rsv = CFG_W'($urandom_range(0, 6));
        endcase
        set_regs(cc, ppc, rsv);
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req        <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_addr     <= REG_CORE_COUNT;
        cfg_wdata    <= '0;
        src_idle     = 1'b0;
        sink_idle    = 1'b1;
        hold_off_req = 1'b0;
        req_cnt      = 0;
        cfg_cnt      = 0;
        idle_cycles  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: core 0 carries the reserve, so the first picks skip it
        send_item(mk_req(ACT_CHOOSE, 0, 0, 0));
        send_item(mk_req(ACT_CHOOSE, 63, 1, 1));
        send_item(mk_req(ACT_ADD_CORE, 0, 0, 0));
        send_item(mk_req(ACT_ADD_CORE, 63, 1, 1));
        send_item(mk_req(ACT_REM_CORE, 5, 0, 0));
        send_item(mk_req(ACT_REM_CORE, 1, 0, 0));
        send_item(mk_req(ACT_REM_CORE, 63, 0, 0));
        send_item(mk_req(ACT_REM_PART, 0, 0, 0));
        send_item(mk_req(ACT_ADD_PART, 0, 0, 0));
        send_item(mk_req(ACT_ADD_PART, 0, 0, 0));
        send_item(mk_req(ACT_REM_PART, 0, 0, 0));
        send_item(mk_req(ACT_QUERY, 0, 1, 0));
        send_item(mk_req(ACT_QUERY, 0, 1, 1));
        send_item(mk_req(ACT_SPARE_6, 63, 1, 1));
        send_item(mk_req(ACT_SPARE_7, 42, 1, 0));

        // zero core count acts as one core; capacity saturates at zero
        set_regs(16'd0, 16'd0, 16'hFFFF);
        send_item(mk_req(ACT_CHOOSE, 0, 0, 0));
        send_item(mk_req(ACT_ADD_CORE, 1, 0, 0));
        send_item(mk_req(ACT_REM_CORE, 0, 0, 0));
        send_item(mk_req(ACT_QUERY, 0, 0, 0));
        send_item(mk_req(ACT_QUERY, 0, 1, 1));

        // core count above the maximum is clamped
        set_regs(16'd127, 16'hFFFF, 16'd0);
        send_item(mk_req(ACT_CHOOSE, 0, 0, 0));
        send_item(mk_req(ACT_CHOOSE, 0, 0, 0));
        send_item(mk_req(ACT_ADD_CORE, 63, 0, 0));
        send_item(mk_req(ACT_REM_CORE, 63, 1, 1));
        send_item(mk_req(ACT_QUERY, 0, 1, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            random_regs();
            if (ph < NUM_PHASES - 2) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end else begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            if (ph == 3) begin
                // receiver holds off while requests keep coming, so the input backs up
                src_idle = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 6 && k == PHASE_ITEMS / 2) settle();
                send_item(random_req(sb.active_cores()));
            end
        end

        settle();
        repeat (100) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            $error("%0d responses never arrived", sb.outstanding());
            sb.mismatches++;
        end
        $display("covered %0d requests and %0d checked responses over %0d register writes",
                 req_cnt, sb.checked, cfg_cnt);
        $display("responses reported full %0d times and error %0d times",
                 sb.full_seen, sb.err_seen);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
